FILE: hdl/gfbr_pkg.sv
// ----------------------------------------------------------------------------
// gfbr_pkg: shared types and constants for the gated FIFO burst release core
// Holds the status codes, the controller states, the per-cell control bundle
// and the fixed field widths of the result channel and the register port.
// ----------------------------------------------------------------------------
package gfbr_pkg;

  // Default sizing of the queue and of a stored identifier.
  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_ID_WIDTH    = 32;

  // Fixed widths of the result fields and of the limit register.
  localparam int STATUS_W    = 3;
  localparam int OUT_ID_W    = 32;
  localparam int OUT_COUNT_W = 7;
  localparam int LIMIT_W     = 7;
  localparam int OUT_DATA_W  = 1 + OUT_ID_W + OUT_COUNT_W;

  // Register port.
  localparam int                  CFG_ADDR_W       = 3;
  localparam int                  CFG_DATA_W       = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BURST_LIMIT = 3'd0;

  // Input kinds carried in the input tuser.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_SWITCH = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_QUEUED        = 3'd0,
    STAT_PASSED        = 3'd1,
    STAT_NONE_WAITING  = 3'd2,
    STAT_RELEASED      = 3'd3,
    STAT_RELEASED_NONE = 3'd4,
    STAT_DROPPED       = 3'd5
  } status_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_RELEASE = 1'b1
  } state_t;

  // Control bundle driven into each queue cell.
  typedef struct packed {
    logic shift;  // take the neighbor's identifier (queue moves toward head)
    logic load;   // take the arriving identifier
  } cell_ctl_t;

endpackage

FILE: hdl/gfbr_cell.sv
// ----------------------------------------------------------------------------
// gfbr_cell: one slot of the shifting identifier queue
// Holds one identifier. On a release every cell takes its upper neighbor's
// value; on an arrival the cell at the fill level takes the new identifier.
// ----------------------------------------------------------------------------
module gfbr_cell #(
  parameter int ID_WIDTH = gfbr_pkg::DEFAULT_ID_WIDTH
) (
  input  logic                 clk,
  input  gfbr_pkg::cell_ctl_t  ctl,
  input  logic [ID_WIDTH-1:0]  nbr_id,
  input  logic [ID_WIDTH-1:0]  load_id,
  output logic [ID_WIDTH-1:0]  id_q
);
  import gfbr_pkg::*;

  logic [ID_WIDTH-1:0] id_r;
  logic [ID_WIDTH-1:0] id_nxt;

  // Shift has priority; the controller never shifts and loads together.
  always_comb begin
    id_nxt = id_r;
    if (ctl.shift) begin
      id_nxt = nbr_id;
    end else if (ctl.load) begin
      id_nxt = load_id;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_q = id_r;

endmodule

FILE: hdl/gated_fifo_burst_release_core.sv
// ----------------------------------------------------------------------------
// gated_fifo_burst_release_core: vehicle queue behind a red/green light
// An arrival transaction, and a switch transaction that does not start a
// burst, gives one result; arrivals can follow each other in consecutive
// cycles while the result channel does not stall. A switch that starts a
// burst of N releases keeps the block busy: it loads the release counter,
// then one release per cycle out of the queue's head cell, paced by the result channel.
// The queue is a row of QUEUE_DEPTH cells that shift toward the head on every
// release. Result fields: out_tuser holds status; out_tdata holds, from the
// lowest bit up, light_green, released_id (32 bits), queue_count (7 bits);
// out_tlast marks the final result of an input transaction. burst_limit lives
// at byte address 0 of the register port.
// ----------------------------------------------------------------------------
module gated_fifo_burst_release_core #(
  parameter int QUEUE_DEPTH = gfbr_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int ID_WIDTH    = gfbr_pkg::DEFAULT_ID_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input channel.
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((ID_WIDTH+7)/8)*8-1:0]           in_tdata,   // vehicle_id
  input  logic                                    in_tuser,   // op
  // Result channel.
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [gfbr_pkg::OUT_DATA_W-1:0]         out_tdata,  // light_green, released_id,
                                                              // queue_count
  output logic [gfbr_pkg::STATUS_W-1:0]           out_tuser,  // status
  output logic                                    out_tlast,  // last
  // Register port.
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [gfbr_pkg::CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [gfbr_pkg::CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [gfbr_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                    cfg_pready
);
  import gfbr_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0]      DEPTH_CNT = CW'(QUEUE_DEPTH);
  localparam logic [LIMIT_W-1:0] DEPTH_LIM = LIMIT_W'(QUEUE_DEPTH);

  // Register port.
  logic [LIMIT_W-1:0] burst_limit_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_BURST_LIMIT) ? CFG_DATA_W'(burst_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_limit_r <= '0;
    end else if (cfg_wr && (cfg_paddr == ADDR_BURST_LIMIT)) begin
      burst_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  // Control state.
  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               green_r, green_nxt;
  logic [LIMIT_W-1:0] rel_left_r, rel_left_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_green_r, out_green_nxt;
  logic [OUT_ID_W-1:0] out_id_r, out_id_nxt;
  logic               out_last_r, out_last_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r, out_count_nxt;

  // Queue row.
  cell_ctl_t          cell_ctl [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] cell_id [QUEUE_DEPTH];
  logic               do_shift, do_push;

  logic               slot_free, in_fire, emit;
  logic [ID_WIDTH-1:0] in_id;
  logic [LIMIT_W-1:0] limit_sat;
  logic               rel_last;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign in_id     = in_tdata[ID_WIDTH-1:0];
  assign limit_sat = (burst_limit_r > DEPTH_LIM) ? DEPTH_LIM : burst_limit_r;
  assign rel_last  = (rel_left_r == LIMIT_W'(1)) || (count_r == CW'(1));

  // Next state of the controller.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == OP_SWITCH) && !green_r &&
            (count_r != '0) && (limit_sat != '0)) begin
          state_nxt = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (slot_free && rel_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs: queue control, light, counters and the next result.
  always_comb begin
    count_nxt      = count_r;
    green_nxt      = green_r;
    rel_left_nxt   = rel_left_r;
    do_shift       = 1'b0;
    do_push        = 1'b0;
    emit           = 1'b0;
    out_status_nxt = out_status_r;
    out_green_nxt  = out_green_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          emit         = 1'b1;
          out_last_nxt = 1'b1;
          out_id_nxt   = '0;
          if (in_tuser == OP_ARRIVE) begin
            out_id_nxt    = OUT_ID_W'(in_id);
            out_green_nxt = green_r;
            if (green_r) begin
              out_status_nxt = STAT_PASSED;
            end else if (count_r >= DEPTH_CNT) begin
              out_status_nxt = STAT_DROPPED;
            end else begin
              out_status_nxt = STAT_QUEUED;
              do_push        = 1'b1;
              count_nxt      = count_r + CW'(1);
            end
          end else if (green_r) begin
            green_nxt      = 1'b0;
            out_status_nxt = STAT_NONE_WAITING;
            out_green_nxt  = 1'b0;
          end else if (count_r == '0) begin
            green_nxt      = 1'b1;
            out_status_nxt = STAT_NONE_WAITING;
            out_green_nxt  = 1'b1;
          end else if (limit_sat == '0) begin
            out_status_nxt = STAT_RELEASED_NONE;
            out_green_nxt  = 1'b0;
          end else begin
            // Burst starts: results come from the release state.
            emit         = 1'b0;
            rel_left_nxt = limit_sat;
          end
        end
      end
      ST_RELEASE: begin
        if (slot_free) begin
          emit           = 1'b1;
          do_shift       = 1'b1;
          out_status_nxt = STAT_RELEASED;
          out_green_nxt  = 1'b1;
          out_id_nxt     = OUT_ID_W'(cell_id[0]);
          out_last_nxt   = rel_last;
          count_nxt      = count_r - CW'(1);
          rel_left_nxt   = rel_last ? '0 : rel_left_r - LIMIT_W'(1);
        end
      end
      default: begin
        rel_left_nxt = '0;
      end
    endcase
    out_count_nxt = OUT_COUNT_W'(count_nxt);
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      green_r     <= 1'b0;
      rel_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      green_r     <= green_nxt;
      rel_left_r  <= rel_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= out_status_nxt;
      out_green_r  <= out_green_nxt;
      out_id_r     <= out_id_nxt;
      out_last_r   <= out_last_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_count_r, out_id_r, out_green_r};
  assign out_tlast  = out_last_r;

  // Row of queue cells; cell 0 is the oldest entry.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nbr = cell_id[i];
    end else begin : g_mid
      assign nbr = cell_id[i+1];
    end
    assign cell_ctl[i].shift = do_shift;
    assign cell_ctl[i].load  = do_push && (count_r == CW'(i));

    gfbr_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .nbr_id  (nbr),
      .load_id (in_id),
      .id_q    (cell_id[i])
    );
  end

  // A burst only runs with something waiting and the light red.
  a_release_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RELEASE |-> (count_r != '0) && !green_r)
    else $error("release state entered with an empty queue or green light");

  // Arrivals on green never queue, so a green light means an empty queue.
  a_green_empty: assert property (@(posedge clk) disable iff (!rst_n)
    green_r |-> count_r == '0)
    else $error("queue holds entries while the light is green");

  // The fill level never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("queue count exceeds depth");

  // The final release of a burst returns the controller to idle.
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELEASE && emit && rel_last) |=> state_r == ST_IDLE)
    else $error("controller stayed in release after the last release");

endmodule
